### src/twrr_pkg.sv
// Shared constants, types and the window test for the rolling window rank block.
package twrr_pkg;

	localparam int WINDOW_DEPTH = 64;
	localparam int VALUE_BITS   = 32;
	localparam int TIME_BITS    = 32;
	localparam int WLEN_BITS    = 32;
	localparam int RANK_BITS    = 8;
	localparam int COUNT_BITS   = 7;

	localparam logic [WLEN_BITS-1:0] WLEN_RESET = WLEN_BITS'(1000);

	// adder tree: popcount of GROUP_SIZE cells, then a sum over the groups
	localparam int GROUP_SIZE = 8;
	localparam int NUM_GROUPS = (WINDOW_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PART_BITS  = $clog2(GROUP_SIZE + 1);
	localparam int SUM_BITS   = $clog2(WINDOW_DEPTH + 2);
	localparam int RANK_FULL_BITS = SUM_BITS + 2;

	localparam int DIFF_BITS = (TIME_BITS > WLEN_BITS) ? TIME_BITS : WLEN_BITS;

	localparam int IN_DATA_BITS  = ((TIME_BITS + VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((RANK_BITS + COUNT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic keep;
		logic larger;
		logic equal;
	} cell_flags_t;

	// An entry stays if it is not older than now - wlen; later times always stay.
	function automatic logic qualifies(input logic [TIME_BITS-1:0] t,
	                                   input logic [TIME_BITS-1:0] now,
	                                   input logic [WLEN_BITS-1:0] wlen);
		logic [TIME_BITS-1:0] diff;
		diff = now - t;
		return (t >= now) || (DIFF_BITS'(diff) <= DIFF_BITS'(wlen));
	endfunction

endpackage

### src/twrr_cell.sv
// One window cell: holds a stored sample, expires it and compares it with the new sample.
module twrr_cell (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   shift_en,
	input  logic                                   fresh,
	input  logic [twrr_pkg::TIME_BITS-1:0]         now,
	input  logic signed [twrr_pkg::VALUE_BITS-1:0] cur_value,
	input  logic [twrr_pkg::WLEN_BITS-1:0]         wlen,
	input  logic [twrr_pkg::TIME_BITS-1:0]         in_time,
	input  logic signed [twrr_pkg::VALUE_BITS-1:0] in_value,
	input  logic                                   in_keep,
	output logic [twrr_pkg::TIME_BITS-1:0]         out_time,
	output logic signed [twrr_pkg::VALUE_BITS-1:0] out_value,
	output logic                                   out_keep,
	output twrr_pkg::cell_flags_t                  flags
);

	logic                                   valid_q;
	logic [twrr_pkg::TIME_BITS-1:0]         time_q;
	logic signed [twrr_pkg::VALUE_BITS-1:0] value_q;
	logic                                   keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift_en) begin
			valid_q <= in_keep;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			time_q  <= in_time;
			value_q <= in_value;
		end
	end

	assign keep = valid_q && !fresh && twrr_pkg::qualifies(time_q, now, wlen);

	assign out_time     = time_q;
	assign out_value    = value_q;
	assign out_keep     = keep;
	assign flags.keep   = keep;
	assign flags.larger = keep && (value_q > cur_value);
	assign flags.equal  = keep && (value_q == cur_value);

endmodule

### src/twrr_sum.sv
// Registered count tree over the cell flags and the output register.
module twrr_sum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  twrr_pkg::cell_flags_t                flags [twrr_pkg::WINDOW_DEPTH],
	input  logic                                 trunc,
	output logic                                 out_valid,
	output logic [twrr_pkg::RANK_BITS-1:0]       rank,
	output logic [twrr_pkg::COUNT_BITS-1:0]      count,
	output logic                                 out_trunc
);

	twrr_pkg::cell_flags_t flags_s1 [twrr_pkg::WINDOW_DEPTH];
	logic                  valid_s1, valid_s2, out_valid_q;
	logic                  trunc_s1, trunc_s2, trunc_q;

	logic [twrr_pkg::PART_BITS-1:0] keep_p   [twrr_pkg::NUM_GROUPS];
	logic [twrr_pkg::PART_BITS-1:0] larger_p [twrr_pkg::NUM_GROUPS];
	logic [twrr_pkg::PART_BITS-1:0] equal_p  [twrr_pkg::NUM_GROUPS];
	logic [twrr_pkg::PART_BITS-1:0] keep_s2   [twrr_pkg::NUM_GROUPS];
	logic [twrr_pkg::PART_BITS-1:0] larger_s2 [twrr_pkg::NUM_GROUPS];
	logic [twrr_pkg::PART_BITS-1:0] equal_s2  [twrr_pkg::NUM_GROUPS];

	logic [twrr_pkg::SUM_BITS-1:0]       keep_sum, larger_sum, equal_sum, cnt;
	logic [twrr_pkg::RANK_FULL_BITS-1:0] rank_full;
	logic [twrr_pkg::RANK_BITS-1:0]      rank_q;
	logic [twrr_pkg::COUNT_BITS-1:0]     count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1  <= flags;
			trunc_s1  <= trunc;
			keep_s2   <= keep_p;
			larger_s2 <= larger_p;
			equal_s2  <= equal_p;
			trunc_s2  <= trunc_s1;
			rank_q    <= twrr_pkg::RANK_BITS'(rank_full);
			count_q   <= twrr_pkg::COUNT_BITS'(cnt);
			trunc_q   <= trunc_s2;
		end
	end

	// per-group popcounts
	always_comb begin
		int idx;
		for (int g = 0; g < twrr_pkg::NUM_GROUPS; g++) begin
			keep_p[g]   = '0;
			larger_p[g] = '0;
			equal_p[g]  = '0;
			for (int m = 0; m < twrr_pkg::GROUP_SIZE; m++) begin
				idx = g * twrr_pkg::GROUP_SIZE + m;
				if (idx < twrr_pkg::WINDOW_DEPTH) begin
					keep_p[g]   = keep_p[g]   + twrr_pkg::PART_BITS'(flags_s1[idx].keep);
					larger_p[g] = larger_p[g] + twrr_pkg::PART_BITS'(flags_s1[idx].larger);
					equal_p[g]  = equal_p[g]  + twrr_pkg::PART_BITS'(flags_s1[idx].equal);
				end
			end
		end
	end

	always_comb begin
		keep_sum   = '0;
		larger_sum = '0;
		equal_sum  = '0;
		for (int g = 0; g < twrr_pkg::NUM_GROUPS; g++) begin
			keep_sum   = keep_sum   + twrr_pkg::SUM_BITS'(keep_s2[g]);
			larger_sum = larger_sum + twrr_pkg::SUM_BITS'(larger_s2[g]);
			equal_sum  = equal_sum  + twrr_pkg::SUM_BITS'(equal_s2[g]);
		end
		// the current sample counts itself
		cnt       = keep_sum + twrr_pkg::SUM_BITS'(1);
		rank_full = {1'b0, cnt, 1'b0} - {1'b0, larger_sum, 1'b0}
		            - twrr_pkg::RANK_FULL_BITS'(equal_sum);
	end

	assign out_valid = out_valid_q;
	assign rank      = rank_q;
	assign count     = count_q;
	assign out_trunc = trunc_q;

endmodule

### src/time_window_rolling_rank_top.sv
// Top level of the rolling time window rank block.
//
// Input stream s_*: s_tdata = {sample_value, sample_time}, s_tuser = new_series.
// Output stream m_*: m_tdata = {pad, window_count, rank_times_two},
// m_tuser = window_truncated. One result per accepted sample, in order.
// Config channel cfg_*: writes window_length; always ready, write only while idle.
//
// The window is a shift chain of WINDOW_DEPTH cells, newest at the head. On each
// accepted sample every cell expires its own entry and compares it with the new
// value in the same cycle, then the chain shifts one place; the entry falling off
// the tail becomes the truncation marker while it would still qualify.
// The result passes the flag register, the group popcount register and the output
// register in turn. Throughput: one sample per cycle while no result waits on m_tready,
// set by the compare and shift of the cell chain, which happen in the same cycle.
// Reset empties the window, clears the truncation marker and loads
// window_length = 1000. While a result waits with m_tready low the whole pipeline
// holds and s_tready stays low until the output register is taken.
module time_window_rolling_rank_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [twrr_pkg::IN_DATA_BITS-1:0]     s_tdata,  // sample_time, sample_value
	input  logic [0:0]                            s_tuser,  // new_series
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [twrr_pkg::OUT_DATA_BITS-1:0]    m_tdata,  // rank_times_two, window_count
	output logic [0:0]                            m_tuser,  // window_truncated
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [twrr_pkg::WLEN_BITS-1:0]        cfg_data
);

	localparam int D = twrr_pkg::WINDOW_DEPTH;

	logic                                   en, accept, fresh;
	logic [twrr_pkg::TIME_BITS-1:0]         now;
	logic signed [twrr_pkg::VALUE_BITS-1:0] cur_value;
	logic [twrr_pkg::WLEN_BITS-1:0]         wlen_q;

	logic [twrr_pkg::TIME_BITS-1:0]         chain_time  [D+1];
	logic signed [twrr_pkg::VALUE_BITS-1:0] chain_value [D+1];
	logic                                   chain_keep  [D+1];
	twrr_pkg::cell_flags_t                  flags       [D];

	logic                                   lost_valid_q, lost_keep;
	logic [twrr_pkg::TIME_BITS-1:0]         lost_time_q;

	logic                                   out_valid, out_trunc;
	logic [twrr_pkg::RANK_BITS-1:0]         rank;
	logic [twrr_pkg::COUNT_BITS-1:0]        count;

	assign now       = s_tdata[twrr_pkg::TIME_BITS-1:0];
	assign cur_value = s_tdata[twrr_pkg::TIME_BITS +: twrr_pkg::VALUE_BITS];
	assign fresh     = s_tuser[0];

	assign en       = !out_valid || m_tready;
	assign s_tready = en;
	assign accept   = s_tvalid && en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= twrr_pkg::WLEN_RESET;
		end else if (cfg_valid) begin
			wlen_q <= cfg_data;
		end
	end

	// head of the chain is the incoming sample
	assign chain_time[0]  = now;
	assign chain_value[0] = cur_value;
	assign chain_keep[0]  = 1'b1;

	for (genvar i = 0; i < D; i++) begin : g_cell
		twrr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift_en  (accept),
			.fresh     (fresh),
			.now       (now),
			.cur_value (cur_value),
			.wlen      (wlen_q),
			.in_time   (chain_time[i]),
			.in_value  (chain_value[i]),
			.in_keep   (chain_keep[i]),
			.out_time  (chain_time[i+1]),
			.out_value (chain_value[i+1]),
			.out_keep  (chain_keep[i+1]),
			.flags     (flags[i])
		);
	end

	// tracks the newest entry pushed off the tail
	assign lost_keep = lost_valid_q && !fresh && twrr_pkg::qualifies(lost_time_q, now, wlen_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lost_valid_q <= 1'b0;
		end else if (accept) begin
			lost_valid_q <= chain_keep[D] || lost_keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && chain_keep[D]) begin
			lost_time_q <= chain_time[D];
		end
	end

	twrr_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.flags     (flags),
		.trunc     (lost_keep),
		.out_valid (out_valid),
		.rank      (rank),
		.count     (count),
		.out_trunc (out_trunc)
	);

	assign m_tvalid   = out_valid;
	assign m_tdata    = twrr_pkg::OUT_DATA_BITS'({count, rank});
	assign m_tuser[0] = out_trunc;

endmodule

### src/twrr_checker.sv
// Port-level checks for the rolling window rank block, bound to the top level.
module twrr_props (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_tvalid,
	input logic                                  s_tready,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [twrr_pkg::OUT_DATA_BITS-1:0]    m_tdata,
	input logic [0:0]                            m_tuser
);

	localparam int RB = twrr_pkg::RANK_BITS;
	localparam int CB = twrr_pkg::COUNT_BITS;

	logic [RB-1:0] rank;
	logic [CB-1:0] count;

	assign rank  = m_tdata[RB-1:0];
	assign count = m_tdata[RB +: CB];

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input only backs up behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

	// the window always holds the current sample
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> count != '0)
		else $error("window count is zero");

	// rank lies between 2 and twice the window count
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (rank >= RB'(2)) && ({1'b0, rank} <= {count, 1'b0}))
		else $error("rank out of range");

	// an accepted sample shows up after the pipeline delay when nothing stalls
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("result missing after accepted sample");

endmodule

bind time_window_rolling_rank_top twrr_props u_twrr_checker (.*);

### verif/twrr_checker.sv
// Checker for the rolling window rank block: predicts each result and compares it.
module twrr_checker
	import twrr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // sample_time, sample_value
	input  logic [0:0]               s_tuser,   // new_series
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic [OUT_DATA_BITS-1:0] m_tdata,   // rank_times_two, window_count
	input  logic [0:0]               m_tuser,   // window_truncated
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [WLEN_BITS-1:0]     cfg_data,
	output int                       pending,
	output int                       fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [RANK_BITS-1:0]  rank2;
		logic [COUNT_BITS-1:0] count;
		logic                  truncated;
	} rank_result_t;

	logic [TIME_BITS-1:0]         kept_time  [WINDOW_DEPTH];
	logic signed [VALUE_BITS-1:0] kept_value [WINDOW_DEPTH];
	logic                         kept_valid [WINDOW_DEPTH];
	int unsigned                  head_slot;
	logic [TIME_BITS-1:0]         dropped_time;
	logic                         dropped_live;
	logic [WLEN_BITS-1:0]         span;

	rank_result_t expected_ranks[$];
	int n_fail = 0;

	function automatic logic in_window(input logic [TIME_BITS-1:0] t,
	                                   input logic [TIME_BITS-1:0] now);
		logic [TIME_BITS-1:0] gap;
		gap = now - t;
		return (t >= now) || (gap <= span);
	endfunction

	// updates the window for one sample and returns its rank result
	function automatic rank_result_t rank_sample(input logic [TIME_BITS-1:0] now,
	                                             input logic signed [VALUE_BITS-1:0] val,
	                                             input logic fresh);
		rank_result_t res;
		int count;
		int above;
		int same;
		int unsigned slot;
		count = 1;
		above = 0;
		same  = 0;
		if (fresh) begin
			foreach (kept_valid[i]) kept_valid[i] = 1'b0;
			dropped_live = 1'b0;
		end
		foreach (kept_valid[i]) begin
			if (kept_valid[i] && !in_window(kept_time[i], now))
				kept_valid[i] = 1'b0;
		end
		if (dropped_live && !in_window(dropped_time, now))
			dropped_live = 1'b0;
		foreach (kept_valid[i]) begin
			if (kept_valid[i]) begin
				count++;
				if (kept_value[i] > val)
					above++;
				else if (kept_value[i] == val)
					same++;
			end
		end
		res.rank2     = RANK_BITS'(2 * count - 2 * above - same);
		res.count     = COUNT_BITS'(count);
		res.truncated = dropped_live;

		// ring write; overwriting a live entry leaves a truncation marker
		slot = (head_slot + 1) % WINDOW_DEPTH;
		if (kept_valid[slot]) begin
			dropped_time = kept_time[slot];
			dropped_live = 1'b1;
		end
		kept_time[slot]  = now;
		kept_value[slot] = val;
		kept_valid[slot] = 1'b1;
		head_slot = slot;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rank_result_t want;
		rank_result_t got;
		if (!arst_n) begin
			foreach (kept_valid[i]) kept_valid[i] = 1'b0;
			head_slot    = 0;
			dropped_time = '0;
			dropped_live = 1'b0;
			span         = WLEN_RESET;
			expected_ranks.delete();
			pending    <= 0;
			fail_count <= n_fail;
		end else begin
			if (cfg_valid && cfg_ready)
				span = cfg_data;
			if (m_tvalid && m_tready) begin
				got.rank2     = m_tdata[RANK_BITS-1:0];
				got.count     = m_tdata[RANK_BITS +: COUNT_BITS];
				got.truncated = m_tuser[0];
				if (expected_ranks.size() == 0) begin
					$error("result transaction with nothing expected: rank_times_two %0d",
					       got.rank2);
					n_fail++;
				end else begin
					want = expected_ranks.pop_front();
					if (got.rank2 !== want.rank2) begin
						$error("rank_times_two: expected %0d, got %0d", want.rank2, got.rank2);
						n_fail++;
					end
					if (got.count !== want.count) begin
						$error("window_count: expected %0d, got %0d", want.count, got.count);
						n_fail++;
					end
					if (got.truncated !== want.truncated) begin
						$error("window_truncated: expected %0d, got %0d",
						       want.truncated, got.truncated);
						n_fail++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_ranks.push_back(rank_sample(s_tdata[TIME_BITS-1:0],
				                                     s_tdata[TIME_BITS +: VALUE_BITS],
				                                     s_tuser[0]));
			pending    <= expected_ranks.size();
			fail_count <= n_fail;
		end
	end

endmodule

### verif/tb.sv
// Testbench top for the rolling window rank block: stimulus, stalls and verdict.
module tb;
	import twrr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;
	localparam int SEG_ITEMS   = 320;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata = '0;
	logic [0:0]               s_tuser = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic [0:0]               m_tuser;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [WLEN_BITS-1:0]     cfg_data = '0;

	int pending;
	int fail_count;
	int snd_idle = 0;
	int rcv_idle = 0;
	int stall_cycles = 0;

	time_window_rolling_rank_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	twrr_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	// watchdog: consecutive cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic send_sample(input logic [TIME_BITS-1:0] t, input logic [VALUE_BITS-1:0] v,
	                           input logic fresh);
		while ($urandom_range(0, 99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {v, t};
		s_tuser  <= fresh;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_window_length(input logic [WLEN_BITS-1:0] len);
		cfg_valid <= 1'b1;
		cfg_data  <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return VALUE_BITS'($urandom_range(0, 8)) - VALUE_BITS'(4);
		if (r < 60) begin
			case ($urandom_range(0, 3))
				0: return {1'b0, {(VALUE_BITS-1){1'b1}}};
				1: return {1'b1, {(VALUE_BITS-1){1'b0}}};
				2: return '0;
				default: return '1;
			endcase
		end
		return VALUE_BITS'($urandom);
	endfunction

	initial begin
		logic [TIME_BITS-1:0] cur_t;
		logic [WLEN_BITS-1:0] wlen_now;
		logic [WLEN_BITS-1:0] hop;
		logic fresh;
		int burst;
		int r;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, default window length of 1000
		send_sample(0, 0, 1'b1);                          // alone in its window
		send_sample(0, 0, 1'b0);                          // tie
		send_sample(1000, 32'h7fff_ffff, 1'b0);           // oldest exactly at the edge
		send_sample(1001, 32'h8000_0000, 1'b0);           // oldest ones drop out
		send_sample(1001, 32'h8000_0000, 1'b0);
		send_sample(600, 32'(-5), 1'b0);                  // time steps backward
		send_sample(1601, 3, 1'b0);
		send_sample(2000, 3, 1'b0);
		send_sample(2000, 2, 1'b1);                       // new series inside a window
		send_sample(2500, 7, 1'b0);
		send_sample(32'hffff_ff00, 1, 1'b0);             // everything expires
		send_sample(32'hffff_ffff, 1, 1'b0);
		send_sample(32'hffff_ffff, 32'(-1), 1'b0);
		send_sample(32'h0000_0010, 9, 1'b0);              // later entries stay
		send_sample(32'h0000_0010, 32'h7fff_ffff, 1'b0);
		send_sample(5000, 4, 1'b0);
		send_sample(5000, 32'h8000_0000, 1'b0);
		send_sample(32'h5555_aaaa, 32'haaaa_5555, 1'b1);
		send_sample(0, 0, 1'b1);
		drain();

		cur_t = '0;
		burst = 0;
		for (int seg = 0; seg < 6; seg++) begin
			case (seg)
				0: wlen_now = 1;
				1: wlen_now = '1;
				2: wlen_now = 20;
				3: wlen_now = 1000;
				4: wlen_now = $urandom_range(32'hffff_ffff, 1);
				default: wlen_now = 300;
			endcase
			write_window_length(wlen_now);
			if (seg < 2) begin
				snd_idle = 19;
				rcv_idle = 84;
			end else if (seg < 4) begin
				snd_idle = 84;
				rcv_idle = 19;
			end else begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			hop = wlen_now / 8 + 1;

			for (int n = 0; n < SEG_ITEMS; n++) begin
				if (n == SEG_ITEMS / 2)
					drain();
				fresh = 1'b0;
				if (burst > 0) begin
					// same timestamp run, which can be long enough to overflow the store
					burst--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 3) begin
						fresh = 1'b1;
						cur_t = (r == 0) ? 32'hffff_fff0 + $urandom_range(0, 15) : $urandom;
					end else if (r < 5) begin
						burst = $urandom_range(60, 80);
					end else if (r < 8) begin
						cur_t = cur_t - $urandom_range(1, 40);
					end else if (r < 35) begin
						// repeat the current time
					end else if (r < 88) begin
						cur_t = cur_t + $urandom_range(1, hop);
					end else begin
						cur_t = cur_t + wlen_now + $urandom_range(0, hop);
					end
				end
				send_sample(cur_t, pick_value(), fresh);
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### time_window_rolling_rank_top.f
src/twrr_pkg.sv
src/twrr_cell.sv
src/twrr_sum.sv
src/time_window_rolling_rank_top.sv
src/twrr_checker.sv
verif/twrr_checker.sv
verif/tb.sv
